FILE: sv/icp_pkg.sv
// Package for the image column projection: sizes, payload words and helpers.
`timescale 1ns / 1ps
`default_nettype none
package icp_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 32;

  localparam int PIX_W   = 32;                 // pixel_value field width
  localparam int COL_W   = 11;                 // column_index width
  localparam int ROW_W   = 12;                 // row counter width
  localparam int SUM_W   = 44;                 // column_sum width
  localparam int CFG_W_W = 12;                 // image_width register
  localparam int CFG_H_W = 13;                 // image_height register
  localparam int CFG_DW  = 13;                 // widest register
  localparam int CFG_IW  = 1;                  // register index width

  typedef enum logic [CFG_IW-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
  } pixel_word_t;

  typedef struct packed {
    logic [COL_W-1:0] column_index;
    logic [SUM_W-1:0] column_sum;
    logic             last_column;
  } sum_word_t;

  // Effective width minus one: 0 acts as 1, above MAX_WIDTH saturates.
  function automatic logic [COL_W-1:0] width_m1(input logic [CFG_W_W-1:0] v);
    logic [CFG_W_W-1:0] e;
    if (v == '0) begin
      e = CFG_W_W'(1);
    end else if (v > CFG_W_W'(MAX_WIDTH)) begin
      e = CFG_W_W'(MAX_WIDTH);
    end else begin
      e = v;
    end
    return COL_W'(e - CFG_W_W'(1));
  endfunction

  // Effective height minus one, same clamping against MAX_HEIGHT.
  function automatic logic [ROW_W-1:0] height_m1(input logic [CFG_H_W-1:0] v);
    logic [CFG_H_W-1:0] e;
    if (v == '0) begin
      e = CFG_H_W'(1);
    end else if (v > CFG_H_W'(MAX_HEIGHT)) begin
      e = CFG_H_W'(MAX_HEIGHT);
    end else begin
      e = v;
    end
    return ROW_W'(e - CFG_H_W'(1));
  endfunction

endpackage
`default_nettype wire

FILE: sv/icp_stream_if.sv
// Valid/ready stream interfaces for pixel words and column sum words.
`timescale 1ns / 1ps
`default_nettype none
interface icp_pixel_if;
  import icp_pkg::*;
  logic        valid;
  logic        ready;
  pixel_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface icp_sum_if;
  import icp_pkg::*;
  logic      valid;
  logic      ready;
  sum_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/image_column_projection.sv
// Top level of the image column projection: per-column pixel sums over a frame.
`timescale 1ns / 1ps
`default_nettype none
// Usage notes
//   in_pixel  : sink of pixel words, raster order, one word per column step.
//   out_sum   : source of column sum words, one per pixel of the last row;
//               last_column flags the final column of the frame.
//   cfg_*     : write port; index 0 = image_width, 1 = image_height. Any write
//               restarts the frame at column 0, row 0. Write only while idle.
// Throughput: one pixel per clock, sustained, as long as out_sum drains.
//   The column store is a 2048 x 44 single-port-write, registered-read RAM;
//   one read-add-write per pixel sets the rate.
// An accepted pixel word is registered into the add stage together with its RAM
//   read; the add result is then registered into the output register, where the
//   sum word becomes valid.
// A pixel of row 0 overwrites its column entry, so the store needs no clearing
//   pass after reset; entries carry no valid bits.
// Back-to-back pixels of the same column (width 1) take the sum from a
//   forwarding register instead of the stale RAM word.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes both counters and
//   sets width and height to 1. When out_sum stalls, the output register holds
//   its word; an add stage holding a last-row pixel holds too and in_pixel.ready
//   drops only once both are full.
module image_column_projection (
  input  wire                          clk,
  input  wire                          rst_n,
  icp_pixel_if.sink                    in_pixel,
  icp_sum_if.source                    out_sum,
  input  wire                          cfg_we,
  input  wire [icp_pkg::CFG_IW-1:0]    cfg_index,
  input  wire [icp_pkg::CFG_DW-1:0]    cfg_data
);
  import icp_pkg::*;

  // configuration, stored as effective size minus one
  logic [COL_W-1:0] wm1_r;
  logic [ROW_W-1:0] hm1_r;

  // position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // column store
  logic [SUM_W-1:0] mem [MAX_WIDTH];
  logic [SUM_W-1:0] rd_data_r;

  // add stage
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_first_r;   // row 0: overwrite
  logic             s1_emit_r;    // last row: report
  logic             s1_last_r;    // last column
  logic             fwd_hit_r;
  logic [SUM_W-1:0] fwd_data_r;
  logic [SUM_W-1:0] s1_oper;
  logic [SUM_W-1:0] s1_sum;
  logic             s1_fire;

  // output register
  logic             out_valid_r;
  sum_word_t        out_data_r;

  logic             in_fire;

  assign s1_fire        = s1_valid_r && (!s1_emit_r || !out_valid_r || out_sum.ready);
  assign in_pixel.ready = !s1_valid_r || s1_fire;
  assign in_fire        = in_pixel.valid && in_pixel.ready;

  assign s1_oper = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign s1_sum  = s1_first_r ? SUM_W'(s1_pix_r) : (s1_oper + SUM_W'(s1_pix_r));

  assign out_sum.valid = out_valid_r;
  assign out_sum.data  = out_data_r;

  // next position after the current pixel
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_r >= wm1_r) begin
      col_nxt = '0;
      row_nxt = (row_r >= hm1_r) ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  // configuration and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r <= '0;
      hm1_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  wm1_r <= width_m1(cfg_data[CFG_W_W-1:0]);
        REG_IMAGE_HEIGHT: hm1_r <= height_m1(cfg_data[CFG_H_W-1:0]);
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // RAM: write from add stage, registered read on accept
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mem[s1_col_r] <= s1_sum;
    end
    if (in_fire) begin
      rd_data_r <= mem[col_r];
    end
  end

  // add stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // add stage payload; forward when the read raced a write to the same column
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r   <= in_pixel.data.pixel_value;
      s1_col_r   <= col_r;
      s1_first_r <= (row_r == '0);
      s1_emit_r  <= (row_r == hm1_r);
      s1_last_r  <= (col_r == wm1_r);
      fwd_hit_r  <= s1_fire && (s1_col_r == col_r);
      fwd_data_r <= s1_sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_sum.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit_r) begin
      out_data_r.column_index <= s1_col_r;
      out_data_r.column_sum   <= s1_sum;
      out_data_r.last_column  <= s1_last_r;
    end
  end

  // checks
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wm1_r)
    else $error("column counter beyond width");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg_we && col_r == wm1_r |=> col_r == '0)
    else $error("column counter failed to wrap");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pixel.ready |-> s1_valid_r && s1_emit_r && out_valid_r)
    else $error("input stalled without a full pipeline");

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_column |-> out_data_r.column_index == wm1_r)
    else $error("last column flag on wrong column");

endmodule
`default_nettype wire

FILE: tb/image_column_projection_checker.sv
// Checker for the image column projection: predicts column sums and compares them.
`timescale 1ns / 1ps
module image_column_projection_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  icp_pixel_if                       pix_mon,
  icp_sum_if                         sum_mon,
  input  logic                       cfg_we,
  input  logic [icp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [icp_pkg::CFG_DW-1:0] cfg_data,
  output int unsigned                mismatch_count,
  output int unsigned                sums_outstanding
);
  import icp_pkg::*;

  localparam logic [SUM_W-1:0] PIX_MASK = SUM_W'((64'd1 << PIXEL_BITS) - 64'd1);

  logic [SUM_W-1:0]   column_totals [MAX_WIDTH];
  logic [CFG_W_W-1:0] width_setting;
  logic [CFG_H_W-1:0] height_setting;
  int unsigned        col_pos;
  int unsigned        row_pos;
  sum_word_t          expected_sums [$];

  initial begin
    mismatch_count   = 0;
    sums_outstanding = 0;
  end

  // 0 acts as 1, anything above the maximum saturates
  function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) begin
      $display("[%0t] column sum mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  task automatic project_pixel(input pixel_word_t word);
    int unsigned      w;
    int unsigned      h;
    logic [SUM_W-1:0] pix;
    logic [SUM_W-1:0] total;
    sum_word_t        res;
    w = clamp_size(width_setting, MAX_WIDTH);
    h = clamp_size(height_setting, MAX_HEIGHT);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    pix = SUM_W'(word.pixel_value) & PIX_MASK;
    // first row overwrites, later rows accumulate
    if (row_pos == 0) begin
      total = pix;
    end else begin
      total = column_totals[col_pos] + pix;
    end
    column_totals[col_pos] = total;
    if (row_pos == h - 1) begin
      res.column_index = COL_W'(col_pos);
      res.column_sum   = total;
      res.last_column  = (col_pos == w - 1);
      expected_sums.push_back(res);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_sum(input sum_word_t got);
    sum_word_t want;
    if (expected_sums.size() == 0) begin
      report_mismatch($sformatf("unexpected word col %0d sum %0d last %0b",
                                got.column_index, got.column_sum, got.last_column));
      return;
    end
    want = expected_sums.pop_front();
    if (got.column_index !== want.column_index) begin
      report_mismatch($sformatf("column_index got %0d want %0d",
                                got.column_index, want.column_index));
    end
    if (got.column_sum !== want.column_sum) begin
      report_mismatch($sformatf("column_sum of col %0d got %0d want %0d",
                                want.column_index, got.column_sum, want.column_sum));
    end
    if (got.last_column !== want.last_column) begin
      report_mismatch($sformatf("last_column of col %0d got %0b want %0b",
                                want.column_index, got.last_column, want.last_column));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_sums.delete();
      col_pos        = 0;
      row_pos        = 0;
      width_setting  = CFG_W_W'(1);
      height_setting = CFG_H_W'(1);
    end else begin
      // output first, so a stray word never matches a fresh expectation
      if (sum_mon.valid && sum_mon.ready) check_sum(sum_mon.data);
      if (pix_mon.valid && pix_mon.ready) project_pixel(pix_mon.data);
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          width_setting = cfg_data[CFG_W_W-1:0];
        end else begin
          height_setting = cfg_data[CFG_H_W-1:0];
        end
        // any write restarts the frame
        col_pos = 0;
        row_pos = 0;
      end
    end
    sums_outstanding = expected_sums.size();
  end

endmodule

FILE: tb/image_column_projection_tb.sv
// Testbench top for the image column projection: stimulus, reset and verdict.
`timescale 1ns / 1ps
module image_column_projection_tb;
  import icp_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 480;
  localparam int unsigned SETTLE_CYCLES = 6;      // pipeline drain plus margin
  localparam int unsigned HOLD_CYCLES   = 300;    // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic clk;
  logic rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  icp_pixel_if in_pixel ();
  icp_sum_if   out_sum ();

  int unsigned check_fails;
  int unsigned pending_sums;
  int unsigned send_idle_pct = 0;   // chance per cycle that the sender holds back
  int unsigned stall_pct     = 0;   // chance per cycle that the receiver stalls
  int unsigned hold_requests = 0;   // bumped by stimulus, served by the receiver
  int unsigned cycle_count   = 0;

  // raw register values as last written, for sizing frames
  logic [CFG_W_W-1:0] width_raw;
  logic [CFG_H_W-1:0] height_raw;

  image_column_projection dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pixel  (in_pixel),
    .out_sum   (out_sum),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  image_column_projection_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pix_mon          (in_pixel),
    .sum_mon          (out_sum),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (check_fails),
    .sums_outstanding (pending_sums)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hang or a missing word ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("image_column_projection_tb NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever stimulus asks for one.
  // The hold is counted here so the sender keeps offering words meanwhile.
  initial begin : sum_receiver
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left     = 0;
    hold_served   = 0;
    out_sum.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_sum.ready <= 1'b0;
      end else begin
        out_sum.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Idling phases: none, sender only, receiver only, both.
  task automatic set_mode(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 49; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 49; end
      default: begin send_idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '1;
    if (pick < 25) return '0;
    return $urandom;
  endfunction

  function automatic int unsigned effective_size(input int unsigned raw, input int unsigned lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high,
  // so back-to-back words never drop valid in between.
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_pixel.valid <= 1'b0;
      @(negedge clk);
    end
    in_pixel.valid <= 1'b1;
    in_pixel.data  <= pixel_word_t'(value);
    @(posedge clk);
    while (!in_pixel.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Wait until every predicted sum has come out, then let pixels that make no
  // sum work through the pipeline before touching the registers.
  task automatic settle_idle();
    in_pixel.valid <= 1'b0;
    while (pending_sums != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_IMAGE_WIDTH) begin
      width_raw = value[CFG_W_W-1:0];
    end else begin
      height_raw = value[CFG_H_W-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [CFG_DW-1:0] wv, input logic [CFG_DW-1:0] hv);
    settle_idle();
    write_reg(REG_IMAGE_WIDTH, wv);
    write_reg(REG_IMAGE_HEIGHT, hv);
  endtask

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned mode;
    int unsigned pick;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned frame_px;
    int unsigned n;
    logic [CFG_DW-1:0] wv;
    logic [CFG_DW-1:0] hv;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_IMAGE_WIDTH;
    cfg_data       = '0;
    in_pixel.valid = 1'b0;
    in_pixel.data  = '0;
    width_raw      = CFG_W_W'(1);
    height_raw     = CFG_H_W'(1);
    random_sent    = 0;
    mode           = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    set_mode(0);

    // reset values give a 1x1 frame: every pixel is a finished last column
    send_pixel('0);
    send_pixel('1);

    // zero in either register behaves as one
    set_frame(0, 0);
    send_pixel(random_pixel());

    // 3x2 frame with extreme pixel values
    set_frame(3, 2);
    repeat (3) send_pixel('1);
    send_pixel('0);
    send_pixel('1);
    send_pixel(random_pixel());

    // single column: the same entry is read right after it is written
    set_frame(1, 3);
    repeat (3) send_pixel('1);

    // register write in the middle of a frame restarts at column 0, row 0
    set_frame(2, 2);
    send_random(3);
    settle_idle();
    write_reg(REG_IMAGE_HEIGHT, 2);
    send_random(4);

    // oversized values saturate; partial first row only, then a 1-row frame
    set_frame(13'h1FFF, 13'h1FFF);
    send_random(2);
    settle_idle();
    write_reg(REG_IMAGE_HEIGHT, 1);
    send_random(3);

    // width write with bit 12 set: only the low 12 bits land in the register
    set_frame(13'h1002, 1);
    send_random(2);

    // ---- back-pressure: receiver holds off while the sender keeps pushing ----
    set_frame(16, 1);
    hold_requests++;
    send_random(48);
    random_sent += 48;

    // ---- random frames, mostly complete, some cut short ----
    while (random_sent < RANDOM_ITEMS) begin
      mode = (mode + 1) % 4;
      set_mode(mode);

      pick = $urandom_range(99);
      if (pick < 60) begin
        wv = CFG_DW'($urandom_range(6, 1));
      end else if (pick < 85) begin
        wv = CFG_DW'($urandom_range(24, 7));
      end else if (pick < 95) begin
        wv = CFG_DW'($urandom_range(64, 25));
      end else begin
        wv = '0;
      end
      if ($urandom_range(9) == 0) wv[12] = 1'b1;    // ignored upper bit

      pick = $urandom_range(99);
      if (effective_size(wv[CFG_W_W-1:0], MAX_WIDTH) > 24) begin
        hv = CFG_DW'($urandom_range(3, 1));
      end else if (pick < 70) begin
        hv = CFG_DW'($urandom_range(5, 1));
      end else if (pick < 92) begin
        hv = CFG_DW'($urandom_range(12, 6));
      end else begin
        hv = '0;
      end

      settle_idle();
      pick = $urandom_range(99);
      if (pick < 70) begin
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);
      end else if (pick < 85) begin
        write_reg(REG_IMAGE_WIDTH, wv);
      end else begin
        write_reg(REG_IMAGE_HEIGHT, hv);
      end

      w_eff    = effective_size(width_raw, MAX_WIDTH);
      h_eff    = effective_size(height_raw, MAX_HEIGHT);
      frame_px = w_eff * h_eff;
      n        = (frame_px > 100) ? frame_px : frame_px * $urandom_range(3, 1);
      // broken frame: a partial tail that the next write abandons
      if (frame_px > 1 && $urandom_range(99) < 20) begin
        n += $urandom_range(frame_px - 1, 1);
      end
      send_random(n);
      random_sent += n;
    end

    // ---- the largest sizes, as short partial frames ----
    set_mode(3);
    set_frame(2048, 1);
    send_random(16);
    // full-scale pixels at the tallest height: first rows of one column only
    set_frame(1, 4096);
    repeat (16) send_pixel('1);

    settle_idle();
    repeat (20) @(negedge clk);

    if (check_fails == 0) begin
      $display("image_column_projection_tb OK");
    end else begin
      $display("image_column_projection_tb NOT OK");
    end
    $finish;
  end

endmodule
